FILE: rtl/core/lcfade_pkg.sv
// Package for the linear LED colour fade block: shared types, fixed widths,
// sequencer state codes and the numerator helper for the step division.
// No dependencies.
package lcfade_pkg;

    localparam int FRAC_BITS = 6;
    localparam int COL_W     = 8;
    localparam int LVL_W     = COL_W + FRAC_BITS;   // 8.6 unsigned level
    localparam int STEP_W    = LVL_W + 1;           // signed step
    localparam int DUR_W     = 16;
    localparam int IDX_W     = 6;
    localparam int NUM_CH    = 3;

    localparam logic [LVL_W-1:0] LEVEL_MAX = '1;
    localparam logic [3:0]       QBIT_TOP  = 4'(LVL_W - 1);
    localparam logic [1:0]       CH_LAST   = 2'(NUM_CH - 1);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [COL_W-1:0]         t_colour;
    typedef logic [LVL_W-1:0]         t_level;
    typedef logic signed [STEP_W-1:0] t_step;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_LDWR  = 6'b000100,
        S_TRD   = 6'b001000,
        S_TCALC = 6'b010000,
        S_TOUT  = 6'b100000
    } t_state;

    // Sign and magnitude of (init - target) << FRAC_BITS.
    function automatic logic [LVL_W:0] num_sign_mag(input t_colour init, input t_colour tgt);
        logic [COL_W:0]   diff;
        logic [COL_W-1:0] mag;
        diff = {1'b0, init} - {1'b0, tgt};
        mag  = diff[COL_W] ? COL_W'(-diff) : diff[COL_W-1:0];
        return {diff[COL_W], mag, {FRAC_BITS{1'b0}}};
    endfunction

endpackage

FILE: rtl/core/led_colour_linear_fade.sv
// Top level of the linear LED colour fade: request channel, result channel,
// duration register, per-LED stores and a shared bit-serial step divider.
// Depends on lcfade_pkg.
//
// Usage:
//  - Slave channel (i_s_axis_*): tuser selects the request kind, 0 loads one
//    LED (index, present colour, target colour), 1 is a refresh tick.
//  - Master channel (o_m_axis_*): a tick returns one result per LED, LED 0
//    first; tlast marks the last LED and stands for the refresh strobe.
//  - Config channel (i_cfg_*): writes fade_duration; always ready. Write it
//    only while the block is idle.
//  - Load: the shared restoring divider produces one quotient bit a cycle,
//    14 bits for each of three channels; a load goes through accept, the
//    divider and one store write. With a zero duration the divider is
//    skipped; a load addressing an LED beyond the string is dropped in the
//    accept cycle.
//  - Tick: each LED passes through store read, level update and result
//    hand-off in turn, and a receiver stall holds the hand-off. The LED store
//    has one read and one write port.
//  - o_s_axis_tready is high only while idle; a request is taken whenever the
//    block is idle.
//  - A receiver stall holds the result register and the walk; nothing drops.
//  - Reset clears the tick count, duration and sequencer. The LED stores
//    hold no reset value: read only LEDs that were loaded.
module led_colour_linear_fade #(
    parameter int NUM_LEDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata, low bit up: led_index[6], initial_red[8], initial_green[8],
    // initial_blue[8], target_red[8], target_green[8], target_blue[8], pad[2]
    input  logic [55:0] i_s_axis_tdata,
    // tuser: req_type[1]
    input  logic        i_s_axis_tuser,
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata, low bit up: out_led[6], out_red[8], out_green[8], out_blue[8], pad[2]
    output logic [31:0] o_m_axis_tdata,
    // tlast: frame_end
    output logic        o_m_axis_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import lcfade_pkg::*;

    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);
    localparam logic [IDX_W:0]   LED_CNT  = (IDX_W + 1)'(NUM_LEDS);

    // control state
    t_state             r_state, n_state;
    logic [DUR_W-1:0]   r_dur;
    logic [DUR_W-1:0]   r_ticks;
    logic               r_out_valid;
    logic [LED_W-1:0]   r_led;
    logic [3:0]         r_bit;
    logic [1:0]         r_ch;

    // payload registers
    logic [LED_W-1:0]            r_addr;
    t_colour [NUM_CH-1:0]        r_init;
    t_colour [NUM_CH-1:0]        r_tgt;
    t_step   [NUM_CH-1:0]        r_step;
    logic [LVL_W-1:0]            r_num;
    logic [DUR_W-1:0]            r_rem;
    logic [LVL_W-1:0]            r_quo;
    logic                        r_neg;
    logic [IDX_W+3*COL_W-1:0]    r_out_data;
    logic                        r_out_last;

    // LED stores and their registered read data
    t_colour [NUM_CH-1:0] mem_tgt [NUM_LEDS];
    t_level  [NUM_CH-1:0] mem_lvl [NUM_LEDS];
    t_step   [NUM_CH-1:0] mem_step[NUM_LEDS];
    t_colour [NUM_CH-1:0] r_rd_tgt;
    t_level  [NUM_CH-1:0] r_rd_lvl;
    t_step   [NUM_CH-1:0] r_rd_step;

    // request decode
    logic             in_acc;
    logic [IDX_W-1:0] in_idx;
    logic             in_hit;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign in_idx = i_s_axis_tdata[IDX_W-1:0];
    assign in_hit = ({1'b0, in_idx} < LED_CNT);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_data};
    assign o_m_axis_tlast  = r_out_last;

    // shared divider: one restoring step per cycle
    logic [DUR_W:0]   div_trial;
    logic             div_qbit;
    logic [DUR_W-1:0] div_rem;
    logic [LVL_W-1:0] div_quo;
    logic [STEP_W-1:0] div_q15;
    t_step            div_step;
    logic [LVL_W:0]   nxt_sm;
    assign div_trial = {r_rem, r_num[LVL_W-1]} - {1'b0, r_dur};
    assign div_qbit  = !div_trial[DUR_W];
    assign div_rem   = div_qbit ? div_trial[DUR_W-1:0] : {r_rem[DUR_W-2:0], r_num[LVL_W-1]};
    assign div_quo   = {r_quo[LVL_W-2:0], div_qbit};
    assign div_q15   = {1'b0, div_quo};
    assign div_step  = r_neg ? t_step'(~div_q15 + 1'b1) : t_step'(div_q15);
    assign nxt_sm    = num_sign_mag(r_init[r_ch + 2'd1], r_tgt[r_ch + 2'd1]);

    // tick update of one LED, all three channels side by side
    t_level  [NUM_CH-1:0] upd_lvl;
    t_colour [NUM_CH-1:0] upd_col;
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            logic signed [LVL_W+2:0] diff;
            diff = $signed({3'b000, r_rd_lvl[c]}) - $signed({{2{r_rd_step[c][STEP_W-1]}}, r_rd_step[c]});
            if (diff[LVL_W+2]) begin
                upd_lvl[c] = '0;
            end else if (diff[LVL_W+1:LVL_W] != 2'b00) begin
                upd_lvl[c] = LEVEL_MAX;
            end else begin
                upd_lvl[c] = diff[LVL_W-1:0];
            end
            upd_col[c] = (r_ticks != '0) ? upd_lvl[c][LVL_W-1:FRAC_BITS] : r_rd_tgt[c];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == REQ_TICK) begin
                        n_state = S_TRD;
                    end else if (in_hit) begin
                        n_state = (r_dur == '0) ? S_LDWR : S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_bit == '0 && r_ch == CH_LAST) begin
                    n_state = S_LDWR;
                end
            end
            S_LDWR:  n_state = S_IDLE;
            S_TRD:   n_state = S_TCALC;
            S_TCALC: n_state = S_TOUT;
            S_TOUT: begin
                if (i_m_axis_tready) begin
                    n_state = (r_led == LED_LAST) ? S_IDLE : S_TRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dur       <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
            r_led       <= '0;
            r_bit       <= '0;
            r_ch        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dur <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_led <= '0;
                    r_bit <= QBIT_TOP;
                    r_ch  <= '0;
                end
                S_DIV: begin
                    // advance bit, then channel
                    if (r_bit == '0) begin
                        r_bit <= QBIT_TOP;
                        r_ch  <= r_ch + 2'd1;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
                S_LDWR:  r_ticks <= r_dur;
                S_TRD:   ;
                S_TCALC: r_out_valid <= 1'b1;
                S_TOUT: begin
                    if (i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_led       <= r_led + 1'b1;
                        if (r_led == LED_LAST && r_ticks != '0) begin
                            r_ticks <= r_ticks - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            logic [LVL_W:0] sm0;
            sm0 = num_sign_mag(i_s_axis_tdata[IDX_W +: COL_W],
                               i_s_axis_tdata[IDX_W + 3*COL_W +: COL_W]);
            r_addr <= in_idx[LED_W-1:0];
            for (int c = 0; c < NUM_CH; c++) begin
                r_init[c] <= i_s_axis_tdata[IDX_W + c*COL_W +: COL_W];
                r_tgt[c]  <= i_s_axis_tdata[IDX_W + (NUM_CH + c)*COL_W +: COL_W];
                r_step[c] <= '0;
            end
            r_neg <= sm0[LVL_W];
            r_num <= sm0[LVL_W-1:0];
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_state == S_DIV) begin
            if (r_bit == '0) begin
                // hold the finished step, load the next numerator
                r_step[r_ch] <= div_step;
                r_neg        <= nxt_sm[LVL_W];
                r_num        <= nxt_sm[LVL_W-1:0];
                r_rem        <= '0;
                r_quo        <= '0;
            end else begin
                r_num <= {r_num[LVL_W-2:0], 1'b0};
                r_rem <= div_rem;
                r_quo <= div_quo;
            end
        end
        if (r_state == S_TCALC) begin
            r_out_data <= {upd_col[2], upd_col[1], upd_col[0], IDX_W'(r_led)};
            r_out_last <= (r_led == LED_LAST);
        end
    end

    // LED stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (r_state == S_LDWR) begin
            mem_tgt[r_addr]  <= r_tgt;
            mem_step[r_addr] <= r_step;
            for (int c = 0; c < NUM_CH; c++) begin
                mem_lvl[r_addr][c] <= {r_init[c], {FRAC_BITS{1'b0}}};
            end
        end else if (r_state == S_TCALC && r_ticks != '0) begin
            mem_lvl[r_led] <= upd_lvl;
        end
        r_rd_tgt  <= mem_tgt[r_led];
        r_rd_lvl  <= mem_lvl[r_led];
        r_rd_step <= mem_step[r_led];
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("request taken while a result is pending");

    a_last_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_led == LED_LAST))
        else $error("frame end on a led other than the last");

    a_ticks_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCALC) |=> $stable(r_ticks))
        else $error("tick count moved in the middle of a walk");

    a_ticks_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LDWR) |=> (r_ticks <= $past(r_ticks)))
        else $error("tick count grew outside a load");

endmodule

FILE: bench/lcfade_checker.sv
// Scoreboard for the linear LED colour fade: watches the request, result and
// configuration channels, predicts each tick's LED colours and compares them.
// Depends on lcfade_pkg.
module lcfade_checker #(
    parameter int NUM_LEDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [55:0] i_req_data,
    input  logic        i_req_kind,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic        i_res_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcfade_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] led;
        t_colour          red;
        t_colour          green;
        t_colour          blue;
        logic             frame_end;
    } t_led_colour;

    // Shadow of the block's stores, shared count and duration register.
    t_colour          target_col [NUM_LEDS][NUM_CH];
    t_level           level_q    [NUM_LEDS][NUM_CH];
    t_step            step_q     [NUM_LEDS][NUM_CH];
    logic [DUR_W-1:0] ticks_left    = '0;
    logic [DUR_W-1:0] fade_duration = '0;

    t_led_colour colour_queue[$];
    int          fails = 0;

    function automatic t_level clamp_level(input int v);
        if (v < 0) return '0;
        if (v > int'(LEVEL_MAX)) return LEVEL_MAX;
        return t_level'(v);
    endfunction

    task automatic load_led(input logic [55:0] d);
        int idx;
        int init_c;
        int tgt_c;
        int num;
        idx = d[5:0];
        // drop loads beyond the string without touching the count
        if (idx >= NUM_LEDS) return;
        for (int c = 0; c < NUM_CH; c++) begin
            init_c = d[6 + COL_W*c +: COL_W];
            tgt_c  = d[30 + COL_W*c +: COL_W];
            num    = (init_c - tgt_c) * (1 << FRAC_BITS);
            target_col[idx][c] = t_colour'(tgt_c);
            level_q[idx][c]    = t_level'(init_c * (1 << FRAC_BITS));
            // signed int division truncates toward zero
            step_q[idx][c] = (fade_duration == '0) ? '0 : t_step'(num / int'(fade_duration));
        end
        ticks_left = fade_duration;
    endtask

    task automatic predict_tick();
        t_led_colour r;
        t_colour     ch [NUM_CH];
        for (int i = 0; i < NUM_LEDS; i++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (ticks_left != '0) begin
                    level_q[i][c] = clamp_level(int'(level_q[i][c]) - int'(step_q[i][c]));
                    ch[c] = level_q[i][c][LVL_W-1:FRAC_BITS];
                end else begin
                    ch[c] = target_col[i][c];
                end
            end
            r.led       = IDX_W'(i);
            r.red       = ch[0];
            r.green     = ch[1];
            r.blue      = ch[2];
            r.frame_end = (i == NUM_LEDS - 1);
            colour_queue.push_back(r);
        end
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
    endtask

    task automatic check_result(input logic [31:0] d, input logic last);
        t_led_colour got;
        t_led_colour want;
        got = {d[5:0], d[13:6], d[21:14], d[29:22], last};
        if (colour_queue.size() == 0) begin
            $display("%0t: unexpected result led=%0d r=%0d g=%0d b=%0d last=%0b", $time,
                     got.led, got.red, got.green, got.blue, got.frame_end);
            fails++;
        end else begin
            want = colour_queue.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected led=%0d r=%0d g=%0d b=%0d last=%0b", $time,
                         want.led, want.red, want.green, want.blue, want.frame_end);
                $display("%0t:          actual   led=%0d r=%0d g=%0d b=%0d last=%0b", $time,
                         got.led, got.red, got.green, got.blue, got.frame_end);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ticks_left    = '0;
            fade_duration = '0;
            colour_queue.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result(i_res_data, i_res_last);
            if (i_cfg_valid && i_cfg_ready) fade_duration = i_cfg_data;
            if (i_req_valid && i_req_ready) begin
                if (i_req_kind == REQ_LOAD) load_led(i_req_data);
                else predict_tick();
            end
        end
        o_pending    <= colour_queue.size();
        o_fail_count <= fails;
    end

endmodule

FILE: bench/tb_led_colour_linear_fade.sv
// Top of the fade testbench: clock, reset, request and duration stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on lcfade_pkg, lcfade_checker and led_colour_linear_fade.
module tb_led_colour_linear_fade;
    timeunit 1ns;
    timeprecision 1ps;

    import lcfade_pkg::*;

    localparam int NUM_LEDS       = 16;
    localparam int SETTLE_CYCLES  = 60;    // covers a load still in its divider and a tick wind-down
    localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 26;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic [55:0] i_s_axis_tdata   = '0;
    logic        i_s_axis_tuser   = REQ_LOAD;
    logic        i_m_axis_tready  = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic [15:0] i_cfg_data       = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    int fail_count;
    int pending;

    // Run statistics for the closing summary.
    int req_total     = 0;
    int load_total    = 0;
    int tick_total    = 0;
    int dropped_total = 0;
    int setting_total = 0;
    int result_total  = 0;
    int idle_cycles   = 0;

    // Idling controls: calm phases run both sides flat out.
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int rx_gap      = 0;
    int rx_roll;

    always #2 i_clk = ~i_clk;

    led_colour_linear_fade #(
        .NUM_LEDS(NUM_LEDS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    lcfade_checker #(
        .NUM_LEDS(NUM_LEDS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_ready (o_s_axis_tready),
        .i_req_data  (i_s_axis_tdata),
        .i_req_kind  (i_s_axis_tuser),
        .i_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .i_res_data  (o_m_axis_tdata),
        .i_res_last  (o_m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver: random ready with mostly short gaps and a few long ones.
    // A new hold request from the stimulus wins over everything and drops
    // ready for a long stretch, counted here.
    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen       <= hold_asked;
            rx_gap          <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap          <= rx_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_calm) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 2) begin
                rx_gap          <= $urandom_range(20, 60);
                i_m_axis_tready <= 1'b0;
            end else if (rx_roll < 25) begin
                rx_gap          <= $urandom_range(0, 3);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready && i_rst_n) result_total <= result_total + 1;
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Sender gap: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_calm || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Skew colours toward the rails so saturation and full swings turn up.
    function automatic t_colour pick_colour();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return t_colour'($urandom_range(0, 255));
    endfunction

    // Offer one request and hold it until the block takes it. Called and
    // returning at a rising edge; the caller lowers tvalid when it stops.
    task automatic send_req(input logic kind, input logic [55:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        req_total++;
    endtask

    task automatic send_load(input int idx, input t_colour ir, input t_colour ig,
                             input t_colour ib, input t_colour tr, input t_colour tg,
                             input t_colour tb);
        send_req(REQ_LOAD, {2'b00, tb, tg, tr, ib, ig, ir, IDX_W'(idx)});
        load_total++;
        if (idx >= NUM_LEDS) dropped_total++;
    endtask

    task automatic send_random_load();
        int idx;
        // a few loads point past the string and must be dropped
        idx = ($urandom_range(0, 99) < 8) ? $urandom_range(NUM_LEDS, 63)
                                          : $urandom_range(0, NUM_LEDS - 1);
        send_load(idx, pick_colour(), pick_colour(), pick_colour(),
                  pick_colour(), pick_colour(), pick_colour());
    endtask

    // Tick payload is don't-care, so fill it with noise.
    task automatic send_tick();
        send_req(REQ_TICK, 56'({$urandom(), $urandom()}));
        tick_total++;
    endtask

    // Wait until every predicted result has come back.
    task automatic drain_results();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_duration(input logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        setting_total++;
    endtask

    // Change the duration only once the block is idle: drain results, then
    // let a load still in its divider finish.
    task automatic settle_and_write(input logic [15:0] d);
        i_s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_duration(d);
    endtask

    initial begin
        int roll;
        logic [15:0] dur;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: short fade, every LED loaded before the first tick
        // so no store entry is ever read unwritten.
        write_duration(16'd3);
        for (int i = 0; i < NUM_LEDS; i++) begin
            if (i == 0)      send_load(i, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
            else if (i == 1) send_load(i, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
            else if (i == 2) send_load(i, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            else if (i == 3) send_load(i, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            else if (i == 4) send_load(i, 8'h55, 8'hAA, 8'h01, 8'hAA, 8'h55, 8'hFE);
            else send_load(i, pick_colour(), pick_colour(), pick_colour(),
                           pick_colour(), pick_colour(), pick_colour());
        end
        send_tick();
        send_tick();
        // load past the string: dropped, count left alone
        send_load(63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_tick();
        send_tick();   // count now zero: exact targets
        // zero duration: step zero, next tick shows targets
        settle_and_write(16'd0);
        send_load(7, 8'd10, 8'd200, 8'd255, 8'd250, 8'd0, 8'd128);
        send_tick();
        // longest duration: steps truncate to zero
        settle_and_write(16'hFFFF);
        send_load(9, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h7F);
        send_tick();

        // Random phases. LEDs keep their state across phases, so a later
        // load with a longer count drives old fades past their targets.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: dur = 16'd1;
                1: dur = 16'd2;
                2: dur = 16'd40;
                3: dur = 16'd0;
                4: dur = 16'hFFFF;
                5: dur = 16'($urandom_range(0, 65535));
                6: dur = 16'd5;
                default: dur = 16'($urandom_range(1, 12));
            endcase
            settle_and_write(dur);
            tx_calm <= (phase == 2);
            rx_calm <= (phase == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold the receiver off and keep offering ticks: fill the block
                if (phase == 3 && k == 8) hold_asked <= hold_asked + 1;
                // pause the sender until everything has come back
                if (phase == 5 && k == 14) begin
                    i_s_axis_tvalid <= 1'b0;
                    drain_results();
                end
                roll = $urandom_range(0, 99);
                if (roll < 40 || (phase == 3 && k >= 8 && k < 11)) send_tick();
                else send_random_load();
            end
        end

        i_s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d loads (%0d outside the string), %0d ticks,",
                 req_total, load_total, dropped_total, tick_total);
        $display("%0d LED results over %0d duration settings, %0d mismatches.",
                 result_total, setting_total, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
